// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under reset.
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under reset.
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, ck, rn, ante, cons)
`define ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

// ===== hw/rtl/asr_pkg.sv =====
package asr_pkg;

    localparam int MAX_NODES  = 64;
    localparam int MAX_EDGES  = 8;
    localparam int NODE_W     = 6;
    localparam int NODE_AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EDGE_DEPTH = MAX_NODES * MAX_EDGES;
    localparam int EDGE_AW    = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
    localparam int EIDX_W     = $clog2(MAX_EDGES + 1);
    localparam int SCAN_W     = $clog2(MAX_NODES + 1);
    localparam int SLOT_W     = 3;
    localparam int CNT_W      = 4;
    localparam int POS_W      = 24;
    localparam int WGT_W      = 16;
    localparam int KIND_W     = 2;
    localparam int COST_W     = 32;
    localparam int MAG_W      = POS_W + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int DIST_W     = MAG_W;

    localparam logic [COST_W-1:0] COST_INF   = '1;
    localparam logic [NODE_W:0]   NODE_LIMIT = (NODE_W + 1)'(MAX_NODES);
    localparam logic              ST_POINT   = 1'b0;
    localparam logic              ST_EMPTY   = 1'b1;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [NODE_W-1:0]       node_id_t;
    typedef logic [COST_W-1:0]       cost_t;

    typedef enum logic [1:0] {
        OP_NODE  = 2'd0,
        OP_EDGE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } asr_op_t;

    typedef struct packed {
        logic [1:0]        operation;
        node_id_t          node_index;
        logic [SLOT_W-1:0] edge_slot;
        pos_t              pos_x;
        pos_t              pos_y;
        pos_t              pos_z;
        logic [CNT_W-1:0]  edge_total;
        node_id_t          neighbor;
        logic [WGT_W-1:0]  edge_cost;
        logic [KIND_W-1:0] edge_kind;
        node_id_t          start_node;
        node_id_t          goal_node;
    } asr_in_t;

    typedef struct packed {
        logic              route_status;
        pos_t              point_x;
        pos_t              point_y;
        pos_t              point_z;
        logic [KIND_W-1:0] arrival_kind;
        logic              last_item;
    } asr_out_t;

    typedef struct packed {
        pos_t x;
        pos_t y;
        pos_t z;
    } asr_pos3_t;

    typedef struct packed {
        asr_pos3_t          pos;
        logic [EIDX_W-1:0]  cnt;
    } asr_node_t;

    typedef struct packed {
        node_id_t          target;
        logic [WGT_W-1:0]  weight;
        logic [KIND_W-1:0] kind;
    } asr_edge_t;

    typedef struct packed {
        node_id_t          parent;
        logic [KIND_W-1:0] kind;
    } asr_link_t;

    // One relaxation write into the search state
    typedef struct packed {
        logic               we;
        logic               link_we;
        logic [NODE_AW-1:0] node;
        cost_t              best;
        cost_t              est;
        asr_link_t          link;
    } asr_upd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_Q_RDG,
        S_Q_RDS,
        S_Q_EST0,
        S_EST_WAIT,
        S_SCAN,
        S_PICK,
        S_EXP_LD,
        S_EDGE_CHK,
        S_EDGE_RD,
        S_EDGE_CMP,
        S_WALK_RD,
        S_WALK_PUT,
        S_EMPTY
    } asr_state_t;

    function automatic cost_t sat_add(cost_t a, cost_t b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_INF : s[COST_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/asr_graph_store.sv =====
module asr_graph_store
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         node_we,
    input  logic [asr_pkg::NODE_AW-1:0]  node_waddr,
    input  asr_pkg::asr_node_t           node_wdata,
    input  logic                         node_re,
    input  logic [asr_pkg::NODE_AW-1:0]  node_raddr,
    output asr_pkg::asr_node_t           node_rdata,
    input  logic                         edge_we,
    input  logic [asr_pkg::EDGE_AW-1:0]  edge_waddr,
    input  asr_pkg::asr_edge_t           edge_wdata,
    input  logic                         edge_re,
    input  logic [asr_pkg::EDGE_AW-1:0]  edge_raddr,
    output asr_pkg::asr_edge_t           edge_rdata
);
    import asr_pkg::*;

    asr_node_t              node_mem [MAX_NODES];
    asr_edge_t              edge_mem [EDGE_DEPTH];
    asr_node_t              node_rd_reg;
    asr_edge_t              edge_rd_reg;
    logic [MAX_NODES-1:0]   cnt_ok_reg;
    logic                   cnt_rd_ok_reg;

    // Node memory: write and registered read
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_rd_reg <= node_mem[node_raddr];
        end
    end

    // Edge memory: write and registered read
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        if (edge_re)
        begin
            edge_rd_reg <= edge_mem[edge_raddr];
        end
    end

    // Track which edge counts were written; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_ok_reg    <= '0;
            cnt_rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (node_we)
            begin
                cnt_ok_reg[node_waddr] <= 1'b1;
            end
            if (node_re)
            begin
                cnt_rd_ok_reg <= cnt_ok_reg[node_raddr];
            end
        end
    end

    // Mask the count of a never-written node
    always_comb
    begin
        node_rdata = node_rd_reg;
        if (!cnt_rd_ok_reg)
        begin
            node_rdata.cnt = '0;
        end
    end

    assign edge_rdata = edge_rd_reg;

endmodule

// ===== hw/rtl/asr_search_state.sv =====
module asr_search_state
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  asr_pkg::asr_upd_t             upd,
    input  logic                          open_clr,
    input  logic [asr_pkg::NODE_AW-1:0]   open_clr_node,
    input  logic                          best_re,
    input  logic [asr_pkg::NODE_AW-1:0]   best_raddr,
    output asr_pkg::cost_t                best_rdata,
    input  logic                          est_re,
    input  logic [asr_pkg::NODE_AW-1:0]   est_raddr,
    output asr_pkg::cost_t                est_rdata,
    input  logic                          link_re,
    input  logic [asr_pkg::NODE_AW-1:0]   link_raddr,
    output asr_pkg::asr_link_t            link_rdata,
    output logic [asr_pkg::MAX_NODES-1:0] open_vec,
    output logic [asr_pkg::MAX_NODES-1:0] has_par_vec
);
    import asr_pkg::*;

    cost_t                best_mem [MAX_NODES];
    cost_t                est_mem  [MAX_NODES];
    asr_link_t            link_mem [MAX_NODES];
    cost_t                best_rd_reg;
    cost_t                est_rd_reg;
    asr_link_t            link_rd_reg;
    logic                 best_ok_reg;
    logic [MAX_NODES-1:0] reached_reg;
    logic [MAX_NODES-1:0] open_reg;
    logic [MAX_NODES-1:0] has_par_reg;

    // Cost, estimate and parent memories
    always_ff @(posedge clk)
    begin
        if (upd.we)
        begin
            best_mem[upd.node] <= upd.best;
            est_mem[upd.node]  <= upd.est;
            if (upd.link_we)
            begin
                link_mem[upd.node] <= upd.link;
            end
        end
        if (best_re)
        begin
            best_rd_reg <= best_mem[best_raddr];
        end
        if (est_re)
        begin
            est_rd_reg <= est_mem[est_raddr];
        end
        if (link_re)
        begin
            link_rd_reg <= link_mem[link_raddr];
        end
    end

    // Per-query flags: drop all on clear, set on relaxation; open bit dropped on pick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= '0;
            open_reg    <= '0;
            has_par_reg <= '0;
            best_ok_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                reached_reg <= '0;
                open_reg    <= '0;
                has_par_reg <= '0;
            end
            else
            begin
                if (upd.we)
                begin
                    reached_reg[upd.node] <= 1'b1;
                    open_reg[upd.node]    <= 1'b1;
                    if (upd.link_we)
                    begin
                        has_par_reg[upd.node] <= 1'b1;
                    end
                end
                if (open_clr)
                begin
                    open_reg[open_clr_node] <= 1'b0;
                end
            end
            if (best_re)
            begin
                best_ok_reg <= reached_reg[best_raddr];
            end
        end
    end

    // An unreached node costs infinity
    assign best_rdata  = best_ok_reg ? best_rd_reg : COST_INF;
    assign est_rdata   = est_rd_reg;
    assign link_rdata  = link_rd_reg;
    assign open_vec    = open_reg;
    assign has_par_vec = has_par_reg;

endmodule

// ===== hw/rtl/asr_dist_unit.sv =====
module asr_dist_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  asr_pkg::asr_pos3_t          pos_a,
    input  asr_pkg::asr_pos3_t          pos_b,
    output logic                        done,
    output logic [asr_pkg::DIST_W-1:0]  root
);
    import asr_pkg::*;

    localparam logic [SQ_W-1:0] ROOT_BIT0 = SQ_W'(1) << (SQ_W - 2);
    localparam logic [SQ_W-1:0] ROOT_LAST = SQ_W'(1);

    asr_pos3_t         a_reg;
    asr_pos3_t         b_reg;
    logic              sq_act_reg;
    logic [1:0]        sq_cnt_reg;
    logic              rt_act_reg;
    logic              done_reg;
    logic [SQ_W-1:0]   prod_reg;
    logic [SQ_W-1:0]   acc_reg;
    logic [SQ_W-1:0]   rem_reg;
    logic [SQ_W-1:0]   res_reg;
    logic [SQ_W-1:0]   bit_reg;
    pos_t              sel_a;
    pos_t              sel_b;
    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]  mag;
    logic [SQ_W-1:0]   prod_w;
    logic [SQ_W-1:0]   trial;
    logic              ge;

    // Pick one axis per cycle and square its difference
    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:
            begin
                sel_a = a_reg.x;
                sel_b = b_reg.x;
            end
            2'd1:
            begin
                sel_a = a_reg.y;
                sel_b = b_reg.y;
            end
            default:
            begin
                sel_a = a_reg.z;
                sel_b = b_reg.z;
            end
        endcase
        diff   = MAG_W'(sel_a) - MAG_W'(sel_b);
        mag    = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        prod_w = mag * mag;
        trial  = res_reg + bit_reg;
        ge     = (rem_reg >= trial);
    end

    // Sequence: three squares, then one root bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_act_reg <= 1'b0;
            sq_cnt_reg <= '0;
            rt_act_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                sq_act_reg <= 1'b1;
                sq_cnt_reg <= '0;
            end
            else if (sq_act_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg + 2'd1;
                if (sq_cnt_reg == 2'd3)
                begin
                    sq_act_reg <= 1'b0;
                    rt_act_reg <= 1'b1;
                end
            end
            else if (rt_act_reg && (bit_reg == ROOT_LAST))
            begin
                rt_act_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

    // Datapath: operands, accumulate, restoring square root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= pos_a;
            b_reg   <= pos_b;
            acc_reg <= '0;
        end
        else if (sq_act_reg)
        begin
            if (sq_cnt_reg != 2'd3)
            begin
                prod_reg <= prod_w;
            end
            if (sq_cnt_reg != 2'd0)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            if (sq_cnt_reg == 2'd3)
            begin
                rem_reg <= acc_reg + prod_reg;
                res_reg <= '0;
                bit_reg <= ROOT_BIT0;
            end
        end
        else if (rt_act_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[DIST_W-1:0];

endmodule

// ===== hw/rtl/astar_route_search_core.sv =====
// Channel | dir | word     | accepted when
// in      | in  | asr_in_t | in_valid && !in_stall
// out     | out | asr_out_t| out_valid && !out_stall
//
// Node and edge writes leave the core idle; a query holds in_stall until its
// last route word is loaded into the output register.
// A query runs setup (goal and start reads, start estimate), then per expansion
// an open-set scan over the single read port of the estimate memory, pick, load
// and the closing edge check; each edge is checked, read and compared, and an
// improved edge also waits on the distance unit (squares, 25 root steps, done);
// route words leave through walk read and put, and a put waits while out_stall holds.
// Reset clears control state and the per-node valid bits; no clearing pass.
`include "assert_macros.svh"
module astar_route_search_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  asr_pkg::asr_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output asr_pkg::asr_out_t out_data
);
    import asr_pkg::*;

    asr_state_t             state_reg, state_next;
    node_id_t               start_reg, start_next;
    node_id_t               goal_reg, goal_next;
    asr_pos3_t              gpos_reg, gpos_next;
    node_id_t               cur_reg, cur_next;
    node_id_t               sel_reg, sel_next;
    cost_t                  sel_est_reg, sel_est_next;
    logic                   found_reg, found_next;
    logic [SCAN_W-1:0]      scan_cnt_reg, scan_cnt_next;
    cost_t                  best_cur_reg, best_cur_next;
    logic [EIDX_W-1:0]      cnt_cur_reg, cnt_cur_next;
    logic [EIDX_W-1:0]      edge_i_reg, edge_i_next;
    node_id_t               nb_reg, nb_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    cost_t                  g_reg, g_next;
    logic                   init_reg, init_next;
    logic [NODE_AW-1:0]     walk_n_reg, walk_n_next;
    logic                   out_valid_reg, out_valid_next;
    asr_out_t               out_data_reg, out_data_next;

    logic                   node_we, node_re;
    logic [NODE_AW-1:0]     node_waddr, node_raddr;
    asr_node_t              node_wdata, node_rdata;
    logic                   edge_we, edge_re;
    logic [EDGE_AW-1:0]     edge_waddr, edge_raddr;
    asr_edge_t              edge_wdata, edge_rdata;
    logic                   clear;
    asr_upd_t               upd;
    logic                   open_clr;
    logic [NODE_AW-1:0]     open_clr_node;
    logic                   best_re, est_re, link_re;
    logic [NODE_AW-1:0]     best_raddr, est_raddr, link_raddr;
    cost_t                  best_rdata, est_rdata;
    asr_link_t              link_rdata;
    logic [MAX_NODES-1:0]   open_vec, has_par_vec;
    logic                   dist_start, dist_done;
    asr_pos3_t              dist_a;
    logic [DIST_W-1:0]      root;

    logic                   accept, out_free, q_bad, node_ok, slot_ok;
    logic                   scan_last, scan_take, edge_end, nb_ok, improve, walk_last;
    logic [SCAN_W-1:0]      scan_prev;
    cost_t                  g_try;
    logic                   pick_hit, sel_open, cur_has_par, same_query;

    asr_graph_store u_graph
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_we    (node_we),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .node_re    (node_re),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .edge_we    (edge_we),
        .edge_waddr (edge_waddr),
        .edge_wdata (edge_wdata),
        .edge_re    (edge_re),
        .edge_raddr (edge_raddr),
        .edge_rdata (edge_rdata)
    );

    asr_search_state u_state
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (clear),
        .upd           (upd),
        .open_clr      (open_clr),
        .open_clr_node (open_clr_node),
        .best_re       (best_re),
        .best_raddr    (best_raddr),
        .best_rdata    (best_rdata),
        .est_re        (est_re),
        .est_raddr     (est_raddr),
        .est_rdata     (est_rdata),
        .link_re       (link_re),
        .link_raddr    (link_raddr),
        .link_rdata    (link_rdata),
        .open_vec      (open_vec),
        .has_par_vec   (has_par_vec)
    );

    asr_dist_unit u_dist
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dist_start),
        .pos_a (dist_a),
        .pos_b (gpos_reg),
        .done  (dist_done),
        .root  (root)
    );

    // Decode conditions
    always_comb
    begin
        accept    = in_valid && !in_stall;
        out_free  = !out_valid_reg || !out_stall;
        node_ok   = {1'b0, in_data.node_index} < NODE_LIMIT;
        slot_ok   = int'(in_data.edge_slot) < MAX_EDGES;
        q_bad     = !({1'b0, in_data.start_node} < NODE_LIMIT)
                 || !({1'b0, in_data.goal_node} < NODE_LIMIT)
                 || (in_data.start_node == in_data.goal_node);
        scan_last = (scan_cnt_reg == SCAN_W'(MAX_NODES));
        scan_prev = scan_cnt_reg - SCAN_W'(1);
        scan_take = (state_reg == S_SCAN) && (scan_cnt_reg != '0)
                 && open_vec[scan_prev[NODE_AW-1:0]]
                 && (!found_reg || (est_rdata < sel_est_reg));
        edge_end  = (edge_i_reg >= cnt_cur_reg);
        nb_ok     = {1'b0, edge_rdata.target} < NODE_LIMIT;
        g_try     = sat_add(best_cur_reg, COST_W'(edge_rdata.weight));
        improve   = (g_try < best_rdata);
        walk_last = (walk_n_reg == NODE_AW'(MAX_NODES - 1))
                 || !has_par_vec[link_rdata.parent[NODE_AW-1:0]];
        pick_hit    = (state_reg == S_PICK) && found_reg;
        sel_open    = open_vec[sel_reg[NODE_AW-1:0]];
        cur_has_par = has_par_vec[cur_reg[NODE_AW-1:0]];
        same_query  = accept && (in_data.operation == OP_QUERY)
                   && (in_data.start_node == in_data.goal_node);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_data.operation == OP_QUERY))
                begin
                    state_next = q_bad ? S_EMPTY : S_Q_RDG;
                end
            end
            S_Q_RDG:    state_next = S_Q_RDS;
            S_Q_RDS:    state_next = S_Q_EST0;
            S_Q_EST0:   state_next = S_EST_WAIT;
            S_EST_WAIT:
            begin
                if (dist_done)
                begin
                    state_next = init_reg ? S_SCAN : S_EDGE_CHK;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (!found_reg)
                begin
                    state_next = S_EMPTY;
                end
                else if (sel_reg == goal_reg)
                begin
                    state_next = S_WALK_RD;
                end
                else
                begin
                    state_next = S_EXP_LD;
                end
            end
            S_EXP_LD:   state_next = S_EDGE_CHK;
            S_EDGE_CHK: state_next = edge_end ? S_SCAN : S_EDGE_RD;
            S_EDGE_RD:  state_next = nb_ok ? S_EDGE_CMP : S_EDGE_CHK;
            S_EDGE_CMP: state_next = improve ? S_EST_WAIT : S_EDGE_CHK;
            S_WALK_RD:  state_next = S_WALK_PUT;
            S_WALK_PUT:
            begin
                if (out_free)
                begin
                    state_next = walk_last ? S_IDLE : S_WALK_RD;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Memory controls and register updates per state
    always_comb
    begin
        start_next    = start_reg;
        goal_next     = goal_reg;
        gpos_next     = gpos_reg;
        cur_next      = cur_reg;
        sel_next      = sel_reg;
        sel_est_next  = sel_est_reg;
        found_next    = found_reg;
        scan_cnt_next = scan_cnt_reg;
        best_cur_next = best_cur_reg;
        cnt_cur_next  = cnt_cur_reg;
        edge_i_next   = edge_i_reg;
        nb_next       = nb_reg;
        kind_next     = kind_reg;
        g_next        = g_reg;
        init_next     = init_reg;
        walk_n_next   = walk_n_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;

        node_we       = 1'b0;
        node_waddr    = in_data.node_index[NODE_AW-1:0];
        node_wdata.pos = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
        node_wdata.cnt = (int'(in_data.edge_total) > MAX_EDGES)
                       ? EIDX_W'(MAX_EDGES) : EIDX_W'(in_data.edge_total);
        node_re       = 1'b0;
        node_raddr    = cur_reg[NODE_AW-1:0];
        edge_we       = 1'b0;
        edge_waddr    = EDGE_AW'(int'(in_data.node_index) * MAX_EDGES
                                 + int'(in_data.edge_slot));
        edge_wdata    = '{target: in_data.neighbor, weight: in_data.edge_cost,
                          kind: in_data.edge_kind};
        edge_re       = 1'b0;
        edge_raddr    = EDGE_AW'(int'(cur_reg) * MAX_EDGES + int'(edge_i_reg));
        clear         = 1'b0;
        upd           = '0;
        upd.node      = nb_reg[NODE_AW-1:0];
        upd.best      = g_reg;
        upd.est       = sat_add(g_reg, COST_W'(root));
        upd.link      = '{parent: cur_reg, kind: kind_reg};
        upd.link_we   = !init_reg;
        open_clr      = 1'b0;
        open_clr_node = sel_reg[NODE_AW-1:0];
        best_re       = 1'b0;
        best_raddr    = sel_reg[NODE_AW-1:0];
        est_re        = 1'b0;
        est_raddr     = scan_cnt_reg[NODE_AW-1:0];
        link_re       = 1'b0;
        link_raddr    = cur_reg[NODE_AW-1:0];
        dist_start    = 1'b0;
        dist_a        = node_rdata.pos;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.operation)
                        OP_NODE:  node_we = node_ok;
                        OP_EDGE:  edge_we = node_ok && slot_ok;
                        OP_QUERY:
                        begin
                            start_next = in_data.start_node;
                            goal_next  = in_data.goal_node;
                            clear      = !q_bad;
                        end
                        default:  ;
                    endcase
                end
            end
            S_Q_RDG:
            begin
                node_re    = 1'b1;
                node_raddr = goal_reg[NODE_AW-1:0];
            end
            S_Q_RDS:
            begin
                gpos_next  = node_rdata.pos;
                node_re    = 1'b1;
                node_raddr = start_reg[NODE_AW-1:0];
            end
            S_Q_EST0:
            begin
                // seed the start node with cost zero
                dist_start = 1'b1;
                nb_next    = start_reg;
                g_next     = '0;
                init_next  = 1'b1;
            end
            S_EST_WAIT:
            begin
                if (dist_done)
                begin
                    upd.we = 1'b1;
                    if (init_reg)
                    begin
                        init_next     = 1'b0;
                        scan_cnt_next = '0;
                        found_next    = 1'b0;
                    end
                    else
                    begin
                        edge_i_next = edge_i_reg + EIDX_W'(1);
                    end
                end
            end
            S_SCAN:
            begin
                // stream estimates; lowest id wins a tie
                est_re = !scan_last;
                if (!scan_last)
                begin
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
                if (scan_take)
                begin
                    found_next   = 1'b1;
                    sel_next     = NODE_W'(scan_prev);
                    sel_est_next = est_rdata;
                end
            end
            S_PICK:
            begin
                if (found_reg)
                begin
                    open_clr    = 1'b1;
                    cur_next    = sel_reg;
                    walk_n_next = '0;
                    if (sel_reg != goal_reg)
                    begin
                        best_re    = 1'b1;
                        node_re    = 1'b1;
                        node_raddr = sel_reg[NODE_AW-1:0];
                    end
                end
            end
            S_EXP_LD:
            begin
                best_cur_next = best_rdata;
                cnt_cur_next  = node_rdata.cnt;
                edge_i_next   = '0;
            end
            S_EDGE_CHK:
            begin
                if (edge_end)
                begin
                    scan_cnt_next = '0;
                    found_next    = 1'b0;
                end
                else
                begin
                    edge_re = 1'b1;
                end
            end
            S_EDGE_RD:
            begin
                nb_next   = edge_rdata.target;
                kind_next = edge_rdata.kind;
                if (nb_ok)
                begin
                    best_re    = 1'b1;
                    best_raddr = edge_rdata.target[NODE_AW-1:0];
                    node_re    = 1'b1;
                    node_raddr = edge_rdata.target[NODE_AW-1:0];
                end
                else
                begin
                    edge_i_next = edge_i_reg + EIDX_W'(1);
                end
            end
            S_EDGE_CMP:
            begin
                if (improve)
                begin
                    g_next     = g_try;
                    dist_start = 1'b1;
                end
                else
                begin
                    edge_i_next = edge_i_reg + EIDX_W'(1);
                end
            end
            S_WALK_RD:
            begin
                node_re = 1'b1;
                link_re = 1'b1;
            end
            S_WALK_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.route_status = ST_POINT;
                    out_data_next.point_x      = node_rdata.pos.x;
                    out_data_next.point_y      = node_rdata.pos.y;
                    out_data_next.point_z      = node_rdata.pos.z;
                    out_data_next.arrival_kind = link_rdata.kind;
                    out_data_next.last_item    = walk_last;
                    cur_next                   = link_rdata.parent;
                    walk_n_next                = walk_n_reg + NODE_AW'(1);
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.route_status = ST_EMPTY;
                    out_data_next.point_x      = '0;
                    out_data_next.point_y      = '0;
                    out_data_next.point_z      = '0;
                    out_data_next.arrival_kind = '0;
                    out_data_next.last_item    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            init_reg      <= 1'b0;
            found_reg     <= 1'b0;
            scan_cnt_reg  <= '0;
            edge_i_reg    <= '0;
            walk_n_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            init_reg      <= init_next;
            found_reg     <= found_next;
            scan_cnt_reg  <= scan_cnt_next;
            edge_i_reg    <= edge_i_next;
            walk_n_reg    <= walk_n_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        goal_reg     <= goal_next;
        gpos_reg     <= gpos_next;
        cur_reg      <= cur_next;
        sel_reg      <= sel_next;
        sel_est_reg  <= sel_est_next;
        best_cur_reg <= best_cur_next;
        cnt_cur_reg  <= cnt_cur_next;
        nb_reg       <= nb_next;
        kind_reg     <= kind_next;
        g_reg        <= g_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `ASSERT_IMPLIES(a_dist_in_wait, clk, rst_n, dist_done, state_reg == S_EST_WAIT)
    `ASSERT_IMPLIES(a_pick_open, clk, rst_n, pick_hit, sel_open)
    `ASSERT_IMPLIES(a_walk_parent, clk, rst_n, state_reg == S_WALK_PUT, cur_has_par)
    `ASSERT_NEXT(a_same_ends, clk, rst_n, same_query, state_reg == S_EMPTY)

endmodule
